// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, control codes, request kinds, register indexes, FSM states and
// the result bundle between the controller and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;

  // field widths
  localparam int KIND_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_W     = 11;
  localparam int CELL_W       = 16;
  localparam int COLOR_W      = 4;
  localparam int ATTR_W       = 2 * COLOR_W;
  localparam int CFG_INDEX_W  = 2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // tab stops every eight columns
  localparam int TAB_STEP = 8;

  // cell content after reset: white space on black
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  // register reset values
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } tcw_kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FG_COLOR = 2'd0,
    REG_BG_COLOR = 2'd1
  } tcw_reg_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DIV,
    ST_ADDR,
    ST_RDATA,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic                    valid;
    logic [CURSOR_W-1:0]     cursor_pos;
    logic [CELL_W-1:0]       cell_data;
  } tcw_result_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl: request sequencer of the text console writer
// Holds the cursor and the row rotation, maps logical cells to RAM addresses,
// runs the fill and row-blank sweeps and the cell-index split for reads.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tcw_pkg::KIND_W-1:0]          kind_i,
  input  logic [tcw_pkg::CHAR_W-1:0]          char_code_i,
  input  logic [tcw_pkg::CELL_INDEX_W-1:0]    cell_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]          attr_i,
  input  logic                                res_ready_i,
  output tcw_pkg::tcw_result_t                res_o,
  output logic                                mem_we_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]     mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]          mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]     mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]          mem_rdata_i
);

  import tcw_pkg::*;

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLUMNS);
  // reciprocal split of a cell index: estimate is low by at most one
  localparam int DivShift = CELL_INDEX_W + 8;
  localparam int DivMult  = (1 << DivShift) / COLUMNS;
  localparam int ProdW    = CELL_INDEX_W + DivShift;

  tcw_state_e state_q, state_d;

  logic [KIND_W-1:0]       kind_q, kind_d;
  logic [CHAR_W-1:0]       char_q, char_d;
  logic [CELL_INDEX_W-1:0] idx_q, idx_d;
  logic [RW-1:0]           row_q, row_d;
  logic [CW-1:0]           col_q, col_d;
  logic [RW-1:0]           top_q, top_d;
  logic [AW-1:0]           addr_q, addr_d;
  logic [AW-1:0]           last_q, last_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [RW-1:0]           qrow_q, qrow_d;
  logic [CW-1:0]           qcol_q, qcol_d;
  logic [CELL_W-1:0]       data_q, data_d;

  logic [CELL_W-1:0]       blank_cell;
  logic                    is_nl, is_cr, is_tab, is_bs, printable;
  logic [CW:0]             tab_sum, tab_col, col_inc;
  logic                    need_line, at_bottom, scroll_go, idx_ok;
  logic [RW-1:0]           arow;
  logic [CW-1:0]           acol;
  logic [RW:0]             prow_sum;
  logic [RW-1:0]           prow;
  logic [AW-1:0]           phys_addr;
  logic [CELL_INDEX_W-1:0] q_est, q_fix, q_times_c, rem_raw, rem_fix;

  assign blank_cell = {attr_i, CH_SPACE};

  // decode of the held put request
  assign is_nl     = (char_q == CH_NEWLINE);
  assign is_cr     = (char_q == CH_RETURN);
  assign is_tab    = (char_q == CH_TAB);
  assign is_bs     = (char_q == CH_BACKSPACE);
  assign printable = !(is_nl || is_cr || is_tab || is_bs);
  assign tab_sum   = {1'b0, col_q} + (CW+1)'(TAB_STEP);
  assign tab_col   = tab_sum & ~(CW+1)'(TAB_STEP - 1);
  assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
  assign need_line = is_nl
                  || (is_tab && (tab_col >= (CW+1)'(COLUMNS)))
                  || (printable && (col_inc == (CW+1)'(COLUMNS)));
  assign at_bottom = (row_q == RW'(ROWS - 1));
  assign scroll_go = (kind_q == KIND_PUT) && need_line && at_bottom;
  assign idx_ok    = (32'(idx_q) < CELLS);

  // logical row rotates by top_q to its physical row
  assign prow_sum  = {1'b0, arow} + {1'b0, top_q};
  assign prow      = (prow_sum >= (RW+1)'(ROWS)) ? RW'(prow_sum - (RW+1)'(ROWS))
                                                 : RW'(prow_sum);
  assign phys_addr = AW'(prow * COLUMNS) + AW'(acol);

  // correction step of the index split
  assign q_est     = prod_q[ProdW-1:DivShift];
  assign q_times_c = CELL_INDEX_W'(q_est * COLUMNS);
  assign rem_raw   = idx_q - q_times_c;
  assign q_fix     = (rem_raw >= CELL_INDEX_W'(COLUMNS)) ? q_est + CELL_INDEX_W'(1) : q_est;
  assign rem_fix   = (rem_raw >= CELL_INDEX_W'(COLUMNS)) ? rem_raw - CELL_INDEX_W'(COLUMNS)
                                                         : rem_raw;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (addr_q == last_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (kind_q)
          KIND_PUT:   state_d = scroll_go ? ST_SWEEP : ST_DONE;
          KIND_CLEAR: state_d = ST_SWEEP;
          KIND_READ:  state_d = idx_ok ? ST_DIV : ST_DONE;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_SWEEP: begin
        if (addr_q == last_q) state_d = ST_DONE;
      end
      ST_DIV:   state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RDATA;
      ST_RDATA: state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    kind_d      = kind_q;
    char_d      = char_q;
    idx_d       = idx_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    addr_d      = addr_q;
    last_d      = last_q;
    prod_d      = prod_q;
    qrow_d      = qrow_q;
    qcol_d      = qcol_q;
    data_d      = data_q;
    arow        = row_q;
    acol        = col_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = phys_addr;
    mem_wdata_o = blank_cell;
    mem_re_o    = 1'b0;
    mem_raddr_o = phys_addr;

    unique case (state_q)
      ST_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_q;
        mem_wdata_o = RESET_CELL;
        addr_d      = addr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          char_d = char_code_i;
          idx_d  = cell_index_i;
        end
      end
      ST_EXEC: begin
        data_d = '0;
        unique case (kind_q)
          KIND_PUT: begin
            if (is_bs) begin
              if (col_q != '0) begin
                acol        = col_q - CW'(1);
                col_d       = col_q - CW'(1);
                mem_we_o    = 1'b1;
                mem_wdata_o = blank_cell;
              end
            end else if (is_cr) begin
              col_d = '0;
            end else if (is_tab) begin
              col_d = CW'(tab_col);
            end else if (printable) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {attr_i, char_q};
              col_d       = CW'(col_inc);
            end
            if (need_line) begin
              col_d = '0;
              if (at_bottom) begin
                // rotate rows and blank the old top row, now the bottom one
                top_d  = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
                addr_d = AW'(top_q * COLUMNS);
                last_d = AW'(top_q * COLUMNS + COLUMNS - 1);
              end else begin
                row_d = row_q + RW'(1);
              end
            end
          end
          KIND_CLEAR: begin
            row_d  = '0;
            col_d  = '0;
            top_d  = '0;
            addr_d = '0;
            last_d = AW'(CELLS - 1);
          end
          KIND_READ: begin
            prod_d = ProdW'(idx_q) * ProdW'(DivMult);
          end
          default: ;
        endcase
      end
      ST_SWEEP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_q;
        mem_wdata_o = blank_cell;
        addr_d      = addr_q + AW'(1);
      end
      ST_DIV: begin
        qrow_d = RW'(q_fix);
        qcol_d = CW'(rem_fix);
      end
      ST_ADDR: begin
        arow     = qrow_q;
        acol     = qcol_q;
        mem_re_o = 1'b1;
      end
      ST_RDATA: begin
        data_d = mem_rdata_i;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign res_o.valid        = (state_q == ST_DONE);
  assign res_o.cursor_pos   = CURSOR_W'(row_q * COLUMNS + 32'(col_q));
  assign res_o.cell_data    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      addr_q  <= '0;
      last_q  <= AW'(CELLS - 1);
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      addr_q  <= addr_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    char_q <= char_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    qrow_q <= qrow_d;
    qcol_q <= qcol_d;
    data_q <= data_d;
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor outside the screen");

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) < ROWS)
    else $error("row rotation outside the screen");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> !(state_q == ST_IDLE || state_q == ST_DONE))
    else $error("cell write while no request is in work");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP || state_q == ST_INIT) |-> (addr_q <= last_q))
    else $error("sweep ran past its last cell");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC))
    else $error("accepted request not taken into work");

endmodule

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Screen of ROWS x COLUMNS 16-bit cells in one RAM, cursor, scrolling by row
// rotation, colour registers and a registered result stage.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_stall_o  kind_i, char_code_i, cell_index_i
//  out       source     out_valid_o/out_stall_i cursor_pos_o, cell_data_o
//  cfg       sink       cfg_we_i               cfg_index_i, cfg_data_i
//
//  A put passes EXEC and DONE; a read passes EXEC, DIV, ADDR, RDATA and DONE, or
//  EXEC and DONE only if its index is off screen. A put that scrolls adds SWEEP,
//  one RAM write per cell of the blanked row; a clear adds SWEEP over every cell.
//  After reset the RAM is swept to 0x0F20 over all ROWS*COLUMNS cells,
//  in_stall_o high meanwhile; configuration writes are taken at all times.
//  A new request is accepted while a result still waits under out_stall_i.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tcw_pkg::KIND_W-1:0]       kind_i,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tcw_pkg::CELL_INDEX_W-1:0] cell_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tcw_pkg::CURSOR_W-1:0]     cursor_pos_o,
  output logic [tcw_pkg::CELL_W-1:0]       cell_data_o,
  input  logic                             cfg_we_i,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data_i
);

  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [COLOR_W-1:0]  fg_q, fg_d;
  logic [COLOR_W-1:0]  bg_q, bg_d;
  logic                out_valid_q, out_valid_d;
  logic [CURSOR_W-1:0] pos_q, pos_d;
  logic [CELL_W-1:0]   data_q, data_d;

  tcw_result_t         res;
  logic                res_ready;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  // register writes
  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FG_COLOR: fg_d = cfg_data_i;
        REG_BG_COLOR: bg_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // result stage: load when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    data_d      = data_q;
    if (res_ready) begin
      out_valid_d = res.valid;
      if (res.valid) begin
        pos_d  = res.cursor_pos;
        data_d = res.cell_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      fg_q        <= fg_d;
      bg_q        <= bg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    data_q <= data_d;
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       ({bg_q, fg_q}),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = pos_q;
  assign cell_data_o  = data_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text console writer
// Drives put, clear, read and unused-kind requests with random gaps and output
// stalls. A scoreboard keeps its own copy of the screen, cursor and colors,
// predicts each result and compares cursor position and cell data. Colors are
// reprogrammed between phases while the console is idle.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int CELLS        = ROWS_DEF * COLUMNS_DEF;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 130;
  localparam int DRAIN_CYCLES = 50;
  // every request a full clear with stalls on top, taken twice over
  localparam int LIMIT_CYCLES = 3_000_000;

  localparam logic [KIND_W-1:0]      KIND_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE  = 2'd3;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   data;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0]  cells [CELLS];
    logic [4:0]         row;
    logic [6:0]         col;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    console_result_t    expected_results [$];
    int errors, checked, puts, clears, reads, spares, scrolls, wraps, color_writes;

    function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      row = '0;
      col = '0;
      fg  = FG_RESET;
      bg  = BG_RESET;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int cell_at();
      return int'(row) * COLUMNS_DEF + int'(col);
    endfunction

    function logic [CELL_W-1:0] blank_cell();
      return {bg, fg, CH_SPACE};
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [COLOR_W-1:0] value);
      color_writes++;
      case (index)
        REG_FG_COLOR: fg = value;
        REG_BG_COLOR: bg = value;
        default: ;
      endcase
    endfunction

    function void scroll_up();
      for (int i = 0; i < CELLS - COLUMNS_DEF; i++) cells[i] = cells[i + COLUMNS_DEF];
      for (int i = CELLS - COLUMNS_DEF; i < CELLS; i++) cells[i] = blank_cell();
      row = 5'(ROWS_DEF - 1);
      scrolls++;
    endfunction

    function void advance_line();
      col = '0;
      row++;
      if (row >= ROWS_DEF) scroll_up();
    endfunction

    function void write_char(logic [CHAR_W-1:0] ch);
      if (ch == CH_NEWLINE) begin
        advance_line();
      end else if (ch == CH_RETURN) begin
        col = '0;
      end else if (ch == CH_TAB) begin
        col = 7'((int'(col) / TAB_STEP + 1) * TAB_STEP);
        if (col >= COLUMNS_DEF) begin
          wraps++;
          advance_line();
        end
      end else if (ch == CH_BACKSPACE) begin
        // nothing to erase at the left margin
        if (col != 0) begin
          col--;
          cells[cell_at()] = blank_cell();
        end
      end else begin
        cells[cell_at()] = {bg, fg, ch};
        col++;
        if (col >= COLUMNS_DEF) begin
          wraps++;
          advance_line();
        end
      end
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                               logic [CELL_INDEX_W-1:0] index);
      console_result_t res;
      res.data = '0;
      case (kind)
        KIND_PUT: begin
          puts++;
          write_char(ch);
        end
        KIND_CLEAR: begin
          clears++;
          foreach (cells[i]) cells[i] = blank_cell();
          row = '0;
          col = '0;
        end
        KIND_READ: begin
          reads++;
          if (index < CELLS) res.data = cells[index];
        end
        default: spares++;
      endcase
      res.cursor = CURSOR_W'(cell_at());
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [CURSOR_W-1:0] cursor, logic [CELL_W-1:0] data);
      console_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got cursor_pos %0d cell_data 0x%04h",
                 $time, cursor, data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (cursor !== want.cursor) begin
        $display("%0t: cursor_pos mismatch, expected %0d, got %0d",
                 $time, want.cursor, cursor);
        errors++;
      end
      if (data !== want.data) begin
        $display("%0t: cell_data mismatch, expected 0x%04h, got 0x%04h",
                 $time, want.data, data);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [KIND_W-1:0]       kind_i       = '0;
  logic [CHAR_W-1:0]       char_code_i  = '0;
  logic [CELL_INDEX_W-1:0] cell_index_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [CURSOR_W-1:0]     cursor_pos_o;
  logic [CELL_W-1:0]       cell_data_o;
  logic                    cfg_we_i     = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index_i  = '0;
  logic [COLOR_W-1:0]      cfg_data_i   = '0;

  bit                calm = 1'b0;
  int                cycles = 0;
  console_scoreboard board;

  text_console_writer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_pos_o (cursor_pos_o),
    .cell_data_o  (cell_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: timed out after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(cursor_pos_o, cell_data_o);
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                              input logic [CELL_INDEX_W-1:0] index);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    char_code_i  <= ch;
    cell_index_i <= index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(kind, ch, index);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned sort;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(999);
    if (pick < 4) begin
      send_request(KIND_CLEAR, CHAR_W'($urandom), CELL_INDEX_W'($urandom));
    end else if (pick < 20) begin
      send_request(KIND_SPARE, CHAR_W'($urandom), CELL_INDEX_W'($urandom));
    end else if (pick < 130) begin
      // half anywhere, half just behind the cursor where the writes land
      if ($urandom_range(1) == 1)
        send_request(KIND_READ, CHAR_W'($urandom), CELL_INDEX_W'($urandom_range(2047)));
      else
        send_request(KIND_READ, CHAR_W'($urandom),
                     CELL_INDEX_W'(board.cell_at() + 2048 - $urandom_range(8)));
    end else begin
      sort = $urandom_range(99);
      if (sort < 18)      ch = CH_NEWLINE;
      else if (sort < 24) ch = CH_TAB;
      else if (sort < 30) ch = CH_BACKSPACE;
      else if (sort < 33) ch = CH_RETURN;
      else                ch = CHAR_W'($urandom_range(255));
      send_request(KIND_PUT, ch, CELL_INDEX_W'($urandom));
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FG_COLOR;
    cfg_data_i  <= fg;
    @(posedge clk_i);
    board.set_register(REG_FG_COLOR, fg);
    cfg_index_i <= REG_BG_COLOR;
    cfg_data_i  <= bg;
    @(posedge clk_i);
    board.set_register(REG_BG_COLOR, bg);
    // unused index must leave both colors alone
    cfg_index_i <= REG_SPARE;
    cfg_data_i  <= COLOR_W'($urandom);
    @(posedge clk_i);
    board.set_register(REG_SPARE, cfg_data_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned burst;
    burst = 0;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset contents, out-of-range read, extreme characters with reset colors
    send_request(KIND_READ, 8'hFF, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd1999);
    send_request(KIND_READ, 8'h5A, 11'd2047);
    send_request(KIND_PUT, 8'h41, 11'd2047);
    send_request(KIND_PUT, 8'h00, 11'd0);
    send_request(KIND_PUT, 8'hFF, 11'h555);
    send_request(KIND_READ, 8'h00, 11'd2);
    settle();
    program_colors(4'd0, 4'd15);
    // control characters, unused kind, clear with new colors
    send_request(KIND_PUT, CH_TAB, 11'h2AA);
    send_request(KIND_PUT, CH_BACKSPACE, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd7);
    send_request(KIND_PUT, CH_RETURN, 11'd0);
    send_request(KIND_PUT, CH_BACKSPACE, 11'd0);
    send_request(KIND_PUT, CH_NEWLINE, 11'd0);
    send_request(KIND_SPARE, 8'hFF, 11'h7FF);
    send_request(KIND_CLEAR, 8'h00, 11'd0);
    send_request(KIND_READ, 8'h00, 11'd1000);
    // tab along the row until it wraps to the next line
    repeat (10) send_request(KIND_PUT, CH_TAB, 11'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: program_colors(4'd7, 4'd1);
        1: program_colors(4'd15, 4'd15);
        2: program_colors(4'd0, 4'd0);
        3: program_colors(FG_RESET, BG_RESET);
        default: program_colors(COLOR_W'($urandom), COLOR_W'($urandom));
      endcase
      calm = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // occasional long printable runs drive column wrap and bottom scroll
        if (burst == 0 && $urandom_range(149) == 0) burst = $urandom_range(100, 60);
        if (burst != 0) begin
          burst--;
          send_request(KIND_PUT, CHAR_W'($urandom_range(126, 32)), CELL_INDEX_W'($urandom));
        end else begin
          send_random_request();
        end
      end
    end
    calm = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("tb: %0d requests (%0d put, %0d clear, %0d read, %0d unused kind), %0d results checked",
             board.puts + board.clears + board.reads + board.spares, board.puts, board.clears,
             board.reads, board.spares, board.checked);
    $display("tb: %0d scrolls, %0d line wraps, %0d register writes, %0d mismatches",
             board.scrolls, board.wraps, board.color_writes, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
test/testbench.sv
